>>> hdl/geostationary_geo_to_pixel_defines.svh
// ----------------------------------------------------------------------------
// Geostationary geo-to-pixel: assertion macros
// Shared property forms for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef GEOSTATIONARY_GEO_TO_PIXEL_DEFINES_SVH
`define GEOSTATIONARY_GEO_TO_PIXEL_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define GG2P_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the following cycle
`define GG2P_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/gg2p_pkg.sv
// ----------------------------------------------------------------------------
// Geostationary geo-to-pixel: shared package
// Types, register codes and elaboration-time constants (angle table, gain,
// ellipsoid ratios) for the fixed-point projection pipeline.
// ----------------------------------------------------------------------------
package gg2p_pkg;

   localparam int FRAC_BITS_DEFAULT     = 32;
   localparam int CORDIC_STAGES_DEFAULT = 32;

   localparam logic [63:0] PI4_Q62 = 64'h3243F6A8885A308D;
   localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C234;
   localparam logic [63:0] DEG_RAD = PI_Q62 / 64'd180;

   localparam logic [63:0] ALT_E4  = 64'd421640000;
   localparam logic [63:0] REQ_E4  = 64'd63781370;
   localparam logic [63:0] RPOL_E4 = 64'd63567523;

   localparam logic signed [63:0] DEG90_Q16  = 64'sd5898240;
   localparam logic signed [63:0] DEG180_Q16 = 64'sd11796480;

   localparam logic [31:0] FACTOR_RESET = 32'hD168_FE29;   // -781648343
   localparam logic [15:0] OFFSET_RESET = 16'd1856;

   typedef enum logic {
      CORDIC_ROTATE,
      CORDIC_VECTOR
   } cordic_mode_type;

   typedef enum logic [1:0] {
      CSR_COLUMN_FACTOR,
      CSR_LINE_FACTOR,
      CSR_COLUMN_OFFSET,
      CSR_LINE_OFFSET
   } csr_index_type;

   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
   } cordic_vec_type;

   // Plain 64-bit long division, one quotient bit per loop pass
   function automatic logic [63:0] div64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      int          i;
      q = '0;
      r = '0;
      for (i = 63; i >= 0; i--) begin
         r = {r[63:0], n[i]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // floor(num / den * 2^frac), zero for a zero divisor
   function automatic logic [63:0] udiv_frac(input logic [63:0] num,
                                              input logic [63:0] den,
                                              input int          frac);
      logic [127:0] n;
      logic [127:0] q;
      logic [128:0] r;
      int           i;
      n = {64'd0, num} << frac;
      q = '0;
      r = '0;
      if (den == 64'd0) begin
         return 64'd0;
      end
      for (i = 127; i >= 0; i--) begin
         r = {r[127:0], n[i]};
         if (r >= {65'd0, den}) begin
            r    = r - {65'd0, den};
            q[i] = 1'b1;
         end
      end
      return q[63:0];
   endfunction

   // floor(sqrt(d * 2^frac))
   function automatic logic [63:0] usqrt_frac(input logic [63:0] d, input int frac);
      logic [127:0] target;
      logic [63:0]  s;
      logic [63:0]  t;
      logic [127:0] tt;
      int           b;
      target = {64'd0, d} << frac;
      s      = '0;
      for (b = frac + 1; b >= 0; b--) begin
         t  = s | (64'd1 << b);
         tt = {64'd0, t} * {64'd0, t};
         if (tt <= target) begin
            s = t;
         end
      end
      return s;
   endfunction

   // atan(2^-i) rounded to frac fraction bits
   function automatic logic signed [63:0] atan_entry(input int i, input int frac);
      logic [63:0] v;
      logic [63:0] term;
      int          k;
      v = '0;
      if (i == 0) begin
         v = PI4_Q62;
      end else begin
         for (k = 0; (2 * k + 1) * i <= 62; k++) begin
            term = div64(64'd1 << (62 - (2 * k + 1) * i), 64'(2 * k + 1));
            if ((k % 2) == 1) begin
               v = v - term;
            end else begin
               v = v + term;
            end
         end
      end
      return $signed((v + (64'd1 << (61 - frac))) >> (62 - frac));
   endfunction

   // Reciprocal of the CORDIC gain over the given number of stages
   function automatic logic signed [63:0] gain_inv(input int stages, input int frac);
      logic [63:0] p;
      int          i;
      p = 64'd1 << 62;
      for (i = 0; i < stages; i++) begin
         if (2 * i < 64) begin
            p = p + (p >> (2 * i));
         end
      end
      p = (p + (64'd1 << (61 - frac))) >> (62 - frac);
      return $signed(udiv_frac(64'd1 << frac, usqrt_frac(p, frac), frac));
   endfunction

   // Polar radius over satellite distance
   function automatic logic signed [63:0] rp_norm(input int frac);
      return $signed(udiv_frac(RPOL_E4, ALT_E4, frac));
   endfunction

   // (polar / equatorial radius) squared, rounded
   function automatic logic signed [63:0] flat_ratio2(input int frac);
      logic [63:0]  rr;
      logic [127:0] pr;
      rr = udiv_frac(RPOL_E4, REQ_E4, frac);
      pr = {64'd0, rr} * {64'd0, rr};
      pr = (pr + (128'd1 << (frac - 1))) >> frac;
      return $signed(pr[63:0]);
   endfunction

   // First eccentricity squared
   function automatic logic signed [63:0] ecc2(input int frac);
      return $signed(64'd1 << frac) - flat_ratio2(frac);
   endfunction

endpackage

>>> hdl/geostationary_geo_to_pixel.sv
// ----------------------------------------------------------------------------
// Geostationary geo-to-pixel
// Maps geodetic longitude/latitude to a pixel of the geostationary scan grid
// through chains of CORDIC, square root and divide cells.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_lon_deg, req_lat_deg
//   rsp      out        rsp_valid/rsp_stall  rsp_pixel_column, rsp_pixel_line,
//                                            rsp_clipped
//   csr      in         csr_wr_en            csr_index, csr_wdata
//
// One request enters per cycle while req_stall is low; each result passes
// through five CORDIC chains, the square root and divide chains and eight
// three-stage multipliers on the longest path.
// Reset empties the pipe and loads the default scale factors and offsets.
// A stalled result held in the output register freezes the whole pipe and
// raises req_stall in the same cycle.
// ----------------------------------------------------------------------------
`include "geostationary_geo_to_pixel_defines.svh"

module geostationary_geo_to_pixel #(
   parameter int FRAC_BITS     = gg2p_pkg::FRAC_BITS_DEFAULT,
   parameter int CORDIC_STAGES = gg2p_pkg::CORDIC_STAGES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [24:0] req_lon_deg,
   input  logic signed [23:0] req_lat_deg,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_pixel_column,
   output logic [15:0]        rsp_pixel_line,
   output logic               rsp_clipped,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int N   = CORDIC_STAGES;
   localparam int F   = FRAC_BITS;
   localparam int LAT = 28 + 5 * N + 2 * F;

   localparam int D_CL   = 3;
   localparam int D_FLIP = 3 + N;
   localparam int D_CS   = 10 + 2 * F;
   localparam int D_CO   = 16 + 2 * N + 2 * F;
   localparam int D_R3   = 6 + N;
   localparam int D_AX   = 3 + N;

   localparam logic signed [63:0] ONE_F   = 64'sd1 <<< F;
   localparam logic signed [63:0] GAIN    = gg2p_pkg::gain_inv(N, F);
   localparam logic signed [63:0] FLAT    = gg2p_pkg::flat_ratio2(F);
   localparam logic signed [63:0] ECC     = gg2p_pkg::ecc2(F);
   localparam logic signed [63:0] DEG_RAD = $signed(gg2p_pkg::DEG_RAD);

   // Handshake and pipe control
   logic             advance;
   logic [LAT:0]     vld_ff;

   // Configuration registers
   logic [31:0]      col_factor_ff, line_factor_ff;
   logic [15:0]      col_offset_ff, line_offset_ff;

   // Datapath
   logic signed [63:0] lat_in, lon_in;
   logic               flip_in;
   logic signed [63:0] lat_ff, lon_ff;
   logic               flip_ff, flip_d;
   logic signed [63:0] latr, lonr, ft, cl_d, cc2, ecos, rc, r3, pm, qm, m2, r3_d;
   logic signed [63:0] cc_d, sc_d, co_f, so_f, co_d, so_d, ax_d, col_m, line_m;
   logic signed [63:0] d_in;
   logic [F:0]         d_ff;
   logic [F:0]         root;
   logic [F+1:0]       rl;
   logic signed [63:0] rl64;
   logic signed [64:0] col_sum, line_sum;
   logic [15:0]        col_in, line_in;
   logic               clip_in;

   gg2p_pkg::cordic_vec_type lat_vin, lat_vout, lon_vin, lon_vout, gc_vin, gc_vout;
   gg2p_pkg::cordic_vec_type cs_vin, cs_vout, ax_vin, ax_vout, ay_vin, ay_vout;

   logic               rsp_valid_ff;
   logic [15:0]        pix_col_ff, pix_line_ff;
   logic               clip_ff;

   // Move the pipe whenever the output register can take a result
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_factor_ff  <= gg2p_pkg::FACTOR_RESET;
         line_factor_ff <= gg2p_pkg::FACTOR_RESET;
         col_offset_ff  <= gg2p_pkg::OFFSET_RESET;
         line_offset_ff <= gg2p_pkg::OFFSET_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            gg2p_pkg::CSR_COLUMN_FACTOR: col_factor_ff  <= csr_wdata;
            gg2p_pkg::CSR_LINE_FACTOR:   line_factor_ff <= csr_wdata;
            gg2p_pkg::CSR_COLUMN_OFFSET: col_offset_ff  <= csr_wdata[15:0];
            gg2p_pkg::CSR_LINE_OFFSET:   line_offset_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Track which pipe slots hold a request
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAT-1:0], req_valid};
      end
   end

   // Saturate latitude, fold longitude into the near hemisphere
   always_comb begin
      lat_in  = 64'(req_lat_deg);
      lon_in  = 64'(req_lon_deg);
      flip_in = 1'b0;
      if (lat_in > gg2p_pkg::DEG90_Q16) begin
         lat_in = gg2p_pkg::DEG90_Q16;
      end else if (lat_in < -gg2p_pkg::DEG90_Q16) begin
         lat_in = -gg2p_pkg::DEG90_Q16;
      end
      if (lon_in > gg2p_pkg::DEG90_Q16) begin
         lon_in  = lon_in - gg2p_pkg::DEG180_Q16;
         flip_in = 1'b1;
      end else if (lon_in < -gg2p_pkg::DEG90_Q16) begin
         lon_in  = lon_in + gg2p_pkg::DEG180_Q16;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lat_ff  <= lat_in;
         lon_ff  <= lon_in;
         flip_ff <= flip_in;
      end
   end

   // Degrees to radians
   gg2p_mul #(.SHIFT(78 - F)) u_mul_lat (
      .clock(clock), .en(advance), .a(lat_ff), .b(DEG_RAD), .p(latr));
   gg2p_mul #(.SHIFT(78 - F)) u_mul_lon (
      .clock(clock), .en(advance), .a(lon_ff), .b(DEG_RAD), .p(lonr));

   // Cosine and sine of latitude and longitude
   assign lat_vin = '{x: GAIN, y: 64'sd0, z: latr};
   assign lon_vin = '{x: GAIN, y: 64'sd0, z: lonr};

   gg2p_cordic #(.FRAC_BITS(F), .CORDIC_STAGES(N), .MODE(gg2p_pkg::CORDIC_ROTATE)) u_cordic_lat (
      .clock(clock), .en(advance), .d_vec(lat_vin), .q_vec(lat_vout));
   gg2p_cordic #(.FRAC_BITS(F), .CORDIC_STAGES(N), .MODE(gg2p_pkg::CORDIC_ROTATE)) u_cordic_lon (
      .clock(clock), .en(advance), .d_vec(lon_vin), .q_vec(lon_vout));

   // Geocentric latitude
   gg2p_mul #(.SHIFT(F)) u_mul_flat (
      .clock(clock), .en(advance), .a(FLAT), .b(lat_vout.y), .p(ft));
   gg2p_delay #(.WIDTH(64), .DEPTH(D_CL)) u_dly_cl (
      .clock(clock), .en(advance), .d(lat_vout.x), .q(cl_d));

   assign gc_vin = '{x: cl_d, y: ft, z: 64'sd0};
   gg2p_cordic #(.FRAC_BITS(F), .CORDIC_STAGES(N), .MODE(gg2p_pkg::CORDIC_VECTOR)) u_cordic_gc (
      .clock(clock), .en(advance), .d_vec(gc_vin), .q_vec(gc_vout));

   assign cs_vin = '{x: GAIN, y: 64'sd0, z: gc_vout.z};
   gg2p_cordic #(.FRAC_BITS(F), .CORDIC_STAGES(N), .MODE(gg2p_pkg::CORDIC_ROTATE)) u_cordic_cs (
      .clock(clock), .en(advance), .d_vec(cs_vin), .q_vec(cs_vout));

   // Ellipsoid radius: rp / sqrt(1 - e2 cos^2)
   gg2p_mul #(.SHIFT(F)) u_mul_cc2 (
      .clock(clock), .en(advance), .a(cs_vout.x), .b(cs_vout.x), .p(cc2));
   gg2p_mul #(.SHIFT(F)) u_mul_ecc (
      .clock(clock), .en(advance), .a(ECC), .b(cc2), .p(ecos));

   assign d_in = ONE_F - ecos;

   always_ff @(posedge clock) begin
      if (advance) begin
         d_ff <= d_in[63] ? '0 : d_in[F:0];
      end
   end

   gg2p_sqrt #(.FRAC_BITS(F)) u_sqrt (
      .clock(clock), .en(advance), .d(d_ff), .root(root));
   gg2p_div #(.FRAC_BITS(F)) u_div (
      .clock(clock), .en(advance), .den(root), .quot(rl));

   assign rl64 = $signed(64'(rl));

   gg2p_delay #(.WIDTH(64), .DEPTH(D_CS)) u_dly_cc (
      .clock(clock), .en(advance), .d(cs_vout.x), .q(cc_d));
   gg2p_delay #(.WIDTH(64), .DEPTH(D_CS)) u_dly_sc (
      .clock(clock), .en(advance), .d(cs_vout.y), .q(sc_d));

   // Satellite-to-point vector
   gg2p_mul #(.SHIFT(F)) u_mul_rc (
      .clock(clock), .en(advance), .a(rl64), .b(cc_d), .p(rc));
   gg2p_mul #(.SHIFT(F)) u_mul_r3 (
      .clock(clock), .en(advance), .a(rl64), .b(sc_d), .p(r3));

   gg2p_delay #(.WIDTH(1), .DEPTH(D_FLIP)) u_dly_flip (
      .clock(clock), .en(advance), .d(flip_ff), .q(flip_d));

   // Negate cosine and sine for a folded longitude
   assign co_f = flip_d ? -lon_vout.x : lon_vout.x;
   assign so_f = flip_d ? -lon_vout.y : lon_vout.y;

   gg2p_delay #(.WIDTH(64), .DEPTH(D_CO)) u_dly_co (
      .clock(clock), .en(advance), .d(co_f), .q(co_d));
   gg2p_delay #(.WIDTH(64), .DEPTH(D_CO)) u_dly_so (
      .clock(clock), .en(advance), .d(so_f), .q(so_d));

   gg2p_mul #(.SHIFT(F)) u_mul_r1 (
      .clock(clock), .en(advance), .a(rc), .b(co_d), .p(pm));
   gg2p_mul #(.SHIFT(F)) u_mul_r2 (
      .clock(clock), .en(advance), .a(rc), .b(so_d), .p(qm));

   // East-west scan angle
   assign ax_vin = '{x: ONE_F - pm, y: qm, z: 64'sd0};
   gg2p_cordic #(.FRAC_BITS(F), .CORDIC_STAGES(N), .MODE(gg2p_pkg::CORDIC_VECTOR)) u_cordic_ax (
      .clock(clock), .en(advance), .d_vec(ax_vin), .q_vec(ax_vout));

   // North-south scan angle from the gain-corrected magnitude
   gg2p_mul #(.SHIFT(F)) u_mul_mag (
      .clock(clock), .en(advance), .a(ax_vout.x), .b(GAIN), .p(m2));
   gg2p_delay #(.WIDTH(64), .DEPTH(D_R3)) u_dly_r3 (
      .clock(clock), .en(advance), .d(r3), .q(r3_d));

   assign ay_vin = '{x: m2, y: -r3_d, z: 64'sd0};
   gg2p_cordic #(.FRAC_BITS(F), .CORDIC_STAGES(N), .MODE(gg2p_pkg::CORDIC_VECTOR)) u_cordic_ay (
      .clock(clock), .en(advance), .d_vec(ay_vin), .q_vec(ay_vout));

   gg2p_delay #(.WIDTH(64), .DEPTH(D_AX)) u_dly_ax (
      .clock(clock), .en(advance), .d(ax_vout.z), .q(ax_d));

   // Scale the angles
   gg2p_mul #(.SHIFT(F + 16)) u_mul_col (
      .clock(clock), .en(advance), .a(ax_d), .b(64'($signed(col_factor_ff))), .p(col_m));
   gg2p_mul #(.SHIFT(F + 16)) u_mul_line (
      .clock(clock), .en(advance), .a(ay_vout.z), .b(64'($signed(line_factor_ff))),
      .p(line_m));

   // Offset and saturate to the index range
   always_comb begin
      col_sum  = 65'(col_m) + $signed({49'd0, col_offset_ff});
      line_sum = 65'(line_m) + $signed({49'd0, line_offset_ff});
      clip_in  = 1'b0;
      if (col_sum < 0) begin
         col_in  = 16'd0;
         clip_in = 1'b1;
      end else if (col_sum > 65'sd65535) begin
         col_in  = 16'hFFFF;
         clip_in = 1'b1;
      end else begin
         col_in = col_sum[15:0];
      end
      if (line_sum < 0) begin
         line_in = 16'd0;
         clip_in = 1'b1;
      end else if (line_sum > 65'sd65535) begin
         line_in = 16'hFFFF;
         clip_in = 1'b1;
      end else begin
         line_in = line_sum[15:0];
      end
   end

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vld_ff[LAT];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pix_col_ff  <= col_in;
         pix_line_ff <= line_in;
         clip_ff     <= clip_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_column = pix_col_ff;
   assign rsp_pixel_line   = pix_line_ff;
   assign rsp_clipped      = clip_ff;

   `GG2P_ASSERT_SAME(a_full_stalls_req, clock, reset, rsp_valid_ff && rsp_stall, req_stall, "held result did not stall requests")
   `GG2P_ASSERT_NEXT(a_pipe_frozen, clock, reset, !advance, $stable(vld_ff), "pipe moved while frozen")
   `GG2P_ASSERT_NEXT(a_last_slot_out, clock, reset, vld_ff[LAT] && advance, rsp_valid_ff, "finished request not presented")

endmodule

>>> hdl/gg2p_delay.sv
// ----------------------------------------------------------------------------
// Geostationary geo-to-pixel: alignment delay
// Shift line that keeps side data in step with the arithmetic chains.
// ----------------------------------------------------------------------------
module gg2p_delay #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   // Advance the line while the pipe moves
   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign q = tap_ff[DEPTH-1];

endmodule

>>> hdl/gg2p_mul.sv
// ----------------------------------------------------------------------------
// Geostationary geo-to-pixel: rounding multiplier
// Signed 64x64 product, rounded to nearest (ties upward) after a fixed right
// shift and saturated, built from four 32x32 partial products over 3 stages.
// ----------------------------------------------------------------------------
module gg2p_mul #(
   parameter int SHIFT = 32
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   output logic signed [63:0] p
);

   localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   logic [63:0]        ua_ff, ub_ff;
   logic               neg_a_ff, neg_b_ff;
   logic [63:0]        p00_ff, p01_ff, p10_ff, p11_ff;
   logic [127:0]       full;
   logic [127:0]       shifted;
   logic [63:0]        mag;
   logic signed [63:0] p_in;
   logic signed [63:0] p_ff;

   // Stage one: take magnitudes and the sign of the product
   always_ff @(posedge clock) begin
      if (en) begin
         ua_ff    <= a[63] ? (64'd0 - a) : a;
         ub_ff    <= b[63] ? (64'd0 - b) : b;
         neg_a_ff <= a[63] ^ b[63];
      end
   end

   // Stage two: partial products
   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff   <= {32'd0, ua_ff[31:0]}  * {32'd0, ub_ff[31:0]};
         p01_ff   <= {32'd0, ua_ff[31:0]}  * {32'd0, ub_ff[63:32]};
         p10_ff   <= {32'd0, ua_ff[63:32]} * {32'd0, ub_ff[31:0]};
         p11_ff   <= {32'd0, ua_ff[63:32]} * {32'd0, ub_ff[63:32]};
         neg_b_ff <= neg_a_ff;
      end
   end

   // Stage three: sum, round, shift, saturate and restore the sign
   always_comb begin
      full = {64'd0, p00_ff}
           + ({64'd0, p01_ff} << 32)
           + ({64'd0, p10_ff} << 32)
           + {p11_ff, 64'd0}
           + (128'd1 << (SHIFT - 1))
           - {127'd0, neg_b_ff};
      shifted = full >> SHIFT;
      mag     = (|shifted[127:63]) ? MAG_MAX : shifted[63:0];
      p_in    = neg_b_ff ? $signed(64'd0 - mag) : $signed(mag);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

>>> hdl/gg2p_cordic_cell.sv
// ----------------------------------------------------------------------------
// Geostationary geo-to-pixel: CORDIC cell
// One micro-rotation by atan(2^-SHIFT), rotation or vectoring steering.
// ----------------------------------------------------------------------------
module gg2p_cordic_cell #(
   parameter int                        SHIFT = 0,
   parameter gg2p_pkg::cordic_mode_type MODE  = gg2p_pkg::CORDIC_ROTATE,
   parameter logic signed [63:0]        ANGLE = 64'sd0
) (
   input  logic                     clock,
   input  logic                     en,
   input  gg2p_pkg::cordic_vec_type d_vec,
   output gg2p_pkg::cordic_vec_type q_vec
);

   gg2p_pkg::cordic_vec_type vec_in;
   gg2p_pkg::cordic_vec_type vec_ff;
   logic signed [63:0]       xs, ys;
   logic                     dir;

   // Steer by the residual angle or by the sign of y
   always_comb begin
      xs = d_vec.x >>> SHIFT;
      ys = d_vec.y >>> SHIFT;
      if (MODE == gg2p_pkg::CORDIC_ROTATE) begin
         dir = !d_vec.z[63];
      end else begin
         dir = d_vec.y[63];
      end
      if (dir) begin
         vec_in.x = d_vec.x - ys;
         vec_in.y = d_vec.y + xs;
         vec_in.z = d_vec.z - ANGLE;
      end else begin
         vec_in.x = d_vec.x + ys;
         vec_in.y = d_vec.y - xs;
         vec_in.z = d_vec.z + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
      end
   end

   assign q_vec = vec_ff;

endmodule

>>> hdl/gg2p_cordic.sv
// ----------------------------------------------------------------------------
// Geostationary geo-to-pixel: CORDIC chain
// A row of cells, one per stage, passing x, y and z on every cycle while en is high.
// ----------------------------------------------------------------------------
module gg2p_cordic #(
   parameter int                        FRAC_BITS     = gg2p_pkg::FRAC_BITS_DEFAULT,
   parameter int                        CORDIC_STAGES = gg2p_pkg::CORDIC_STAGES_DEFAULT,
   parameter gg2p_pkg::cordic_mode_type MODE          = gg2p_pkg::CORDIC_ROTATE
) (
   input  logic                     clock,
   input  logic                     en,
   input  gg2p_pkg::cordic_vec_type d_vec,
   output gg2p_pkg::cordic_vec_type q_vec
);

   gg2p_pkg::cordic_vec_type link [CORDIC_STAGES+1];

   assign link[0] = d_vec;

   // Chain the cells, stage i rotating by atan(2^-i)
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      gg2p_cordic_cell #(
         .SHIFT (i),
         .MODE  (MODE),
         .ANGLE (gg2p_pkg::atan_entry(i, FRAC_BITS))
      ) u_cell (
         .clock (clock),
         .en    (en),
         .d_vec (link[i]),
         .q_vec (link[i+1])
      );
   end

   assign q_vec = link[CORDIC_STAGES];

endmodule

>>> hdl/gg2p_sqrt.sv
// ----------------------------------------------------------------------------
// Geostationary geo-to-pixel: square root chain
// floor(sqrt(d * 2^FRAC_BITS)) one root bit per stage, restoring form.
// ----------------------------------------------------------------------------
module gg2p_sqrt #(
   parameter int FRAC_BITS = gg2p_pkg::FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               en,
   input  logic [FRAC_BITS:0] d,
   output logic [FRAC_BITS:0] root
);

   localparam int STEPS = FRAC_BITS + 1;
   localparam int RW    = 2 * FRAC_BITS + 2;

   logic [RW-1:0]      rem_ff  [STEPS];
   logic [FRAC_BITS:0] root_ff [STEPS];

   // One stage decides root bit FRAC_BITS-k
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam int B = FRAC_BITS - k;
      logic [RW-1:0]      rem_cur;
      logic [FRAC_BITS:0] root_cur;
      logic [RW-1:0]      trial;
      logic [RW-1:0]      rem_in;
      logic [FRAC_BITS:0] root_in;

      if (k == 0) begin : g_first
         assign rem_cur  = RW'(d) << FRAC_BITS;
         assign root_cur = '0;
      end else begin : g_next
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
      end

      always_comb begin
         trial = (RW'(root_cur) << (B + 1)) + (RW'(1) << (2 * B));
         if (rem_cur >= trial) begin
            rem_in  = rem_cur - trial;
            root_in = root_cur | ((FRAC_BITS+1)'(1) << B);
         end else begin
            rem_in  = rem_cur;
            root_in = root_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign root = root_ff[STEPS-1];

endmodule

>>> hdl/gg2p_div.sv
// ----------------------------------------------------------------------------
// Geostationary geo-to-pixel: radius divider chain
// floor(rp_norm * 2^FRAC_BITS / den), one quotient bit per stage; a zero
// divisor gives zero.
// ----------------------------------------------------------------------------
module gg2p_div #(
   parameter int FRAC_BITS = gg2p_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [FRAC_BITS:0]   den,
   output logic [FRAC_BITS+1:0] quot
);

   localparam int QB = FRAC_BITS + 2;
   localparam int DW = 2 * FRAC_BITS + 3;
   localparam logic [DW-1:0] NUM = DW'(gg2p_pkg::rp_norm(FRAC_BITS)) << FRAC_BITS;

   logic [DW-1:0]      rem_ff [QB];
   logic [QB-1:0]      q_ff   [QB];
   logic [FRAC_BITS:0] den_ff [QB];

   // One stage decides quotient bit QB-1-k
   for (genvar k = 0; k < QB; k++) begin : g_step
      localparam int J = QB - 1 - k;
      logic [DW-1:0]      rem_cur;
      logic [QB-1:0]      q_cur;
      logic [FRAC_BITS:0] den_cur;
      logic [DW-1:0]      trial;
      logic [DW-1:0]      rem_in;
      logic [QB-1:0]      q_in;

      if (k == 0) begin : g_first
         assign rem_cur = NUM;
         assign q_cur   = '0;
         assign den_cur = den;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign q_cur   = q_ff[k-1];
         assign den_cur = den_ff[k-1];
      end

      always_comb begin
         trial = DW'(den_cur) << J;
         if (rem_cur >= trial) begin
            rem_in = rem_cur - trial;
            q_in   = q_cur | (QB'(1) << J);
         end else begin
            rem_in = rem_cur;
            q_in   = q_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            q_ff[k]   <= q_in;
            den_ff[k] <= den_cur;
         end
      end
   end

   assign quot = (den_ff[QB-1] == '0) ? '0 : q_ff[QB-1];

endmodule
